[rtl/ncps_pkg.sv]
package ncps_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FSIZE_W    = 12;
  localparam int unsigned CMP_W      = 14;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned SQ_W       = 16;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned PROD_W     = 36;
  localparam int unsigned QUOT_W     = 15;
  localparam int unsigned QUOT_SHIFT = 20;
  localparam int unsigned DIST_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  // ceil(2^20 / 6); exact floor(S / 6) for every S below 2^19.
  localparam logic [SUM_W-1:0] RECIP6 = SUM_W'(174763);

  localparam logic [DIST_W-1:0] DIST_INIT = DIST_W'(255);
  localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(180);

  localparam logic [PIX_W-1:0]   REF_RST    = PIX_W'(100);
  localparam logic [FSIZE_W-1:0] WIDTH_RST  = FSIZE_W'(640);
  localparam logic [FSIZE_W-1:0] HEIGHT_RST = FSIZE_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_LUMA        = 3'd0,
    CFG_REF_RED_CHROMA  = 3'd1,
    CFG_REF_BLUE_CHROMA = 3'd2,
    CFG_FRAME_WIDTH     = 3'd3,
    CFG_FRAME_HEIGHT    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] red_chroma;
    logic [PIX_W-1:0] blue_chroma;
  } color_t;

endpackage

[rtl/nearest_color_pixel_search.sv]
// Channel  Direction  Handshake                  Payload
// pixel    in         in_valid_i / in_ready_o    luma_i, red_chroma_i, blue_chroma_i
// result   out        out_valid_o / out_ready_i  best_column_o, best_row_o
// config   in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// One pixel word is taken every cycle unless the pipeline stalls; the rate is set by the distance
// pipeline (difference squares, divide by six, square root, minimum tracking).
// The result word is registered once the frame's last pixel leaves the distance pipeline.
// Reset restores the reference color 100/100/100, a 640 by 480 frame and an empty search.
// The pixel side stalls only when a frame-end pixel reaches the tracker while the
// previous result word is still waiting in the output register.
module nearest_color_pixel_search #(
  parameter int unsigned MAX_WIDTH  = ncps_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ncps_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ncps_pkg::PIX_W-1:0]      luma_i,
  input  logic [ncps_pkg::PIX_W-1:0]      red_chroma_i,
  input  logic [ncps_pkg::PIX_W-1:0]      blue_chroma_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ncps_pkg::COORD_W-1:0]    best_column_o,
  output logic [ncps_pkg::COORD_W-1:0]    best_row_o,
  input  logic                            cfg_we_i,
  input  logic [ncps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ncps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ncps_pkg::*;

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned TagW = ColW + RowW + 1;

  color_t              ref_q;
  logic [FSIZE_W-1:0]  width_q, height_q;
  color_t              pixel;
  logic                acc;
  logic [ColW-1:0]     scan_col, trk_col;
  logic [RowW-1:0]     scan_row, trk_row;
  logic                scan_end, trk_end;
  logic [TagW-1:0]     tag_in, tag_out;
  logic                dv, dready;
  logic [DIST_W-1:0]   pix_dist;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q.luma        <= REF_RST;
      ref_q.red_chroma  <= REF_RST;
      ref_q.blue_chroma <= REF_RST;
      width_q           <= WIDTH_RST;
      height_q          <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_REF_LUMA:        ref_q.luma        <= cfg_data_i[PIX_W-1:0];
        CFG_REF_RED_CHROMA:  ref_q.red_chroma  <= cfg_data_i[PIX_W-1:0];
        CFG_REF_BLUE_CHROMA: ref_q.blue_chroma <= cfg_data_i[PIX_W-1:0];
        CFG_FRAME_WIDTH:     width_q           <= cfg_data_i[FSIZE_W-1:0];
        CFG_FRAME_HEIGHT:    height_q          <= cfg_data_i[FSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign acc               = in_valid_i && in_ready_o;
  assign pixel.luma        = luma_i;
  assign pixel.red_chroma  = red_chroma_i;
  assign pixel.blue_chroma = blue_chroma_i;
  assign tag_in            = {scan_end, scan_row, scan_col};
  assign {trk_end, trk_row, trk_col} = tag_out;

  ncps_scan #(
    .MaxWidth (MAX_WIDTH),
    .MaxHeight(MAX_HEIGHT),
    .ColW     (ColW),
    .RowW     (RowW)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .frame_width_i (width_q),
    .frame_height_i(height_q),
    .col_o         (scan_col),
    .row_o         (scan_row),
    .frame_end_o   (scan_end)
  );

  ncps_dist #(
    .TagW(TagW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .pixel_i(pixel),
    .ref_i  (ref_q),
    .tag_i  (tag_in),
    .valid_o(dv),
    .ready_i(dready),
    .dist_o (pix_dist),
    .tag_o  (tag_out)
  );

  ncps_track #(
    .ColW(ColW),
    .RowW(RowW)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (dv),
    .ready_o      (dready),
    .dist_i       (pix_dist),
    .col_i        (trk_col),
    .row_i        (trk_row),
    .frame_end_i  (trk_end),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .best_column_o(best_column_o),
    .best_row_o   (best_row_o)
  );

endmodule

[rtl/ncps_scan.sv]
module ncps_scan #(
  parameter int unsigned MaxWidth  = ncps_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = ncps_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned ColW      = 11,
  parameter int unsigned RowW      = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic [ncps_pkg::FSIZE_W-1:0]  frame_width_i,
  input  logic [ncps_pkg::FSIZE_W-1:0]  frame_height_i,
  output logic [ColW-1:0]               col_o,
  output logic [RowW-1:0]               row_o,
  output logic                          frame_end_o
);
  import ncps_pkg::*;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [CMP_W-1:0] eff_w, eff_h, last_col, last_row;
  logic             row_end;

  always_comb begin
    if (frame_width_i == '0) begin
      eff_w = CMP_W'(1);
    end else if (CMP_W'(frame_width_i) > CMP_W'(MaxWidth)) begin
      eff_w = CMP_W'(MaxWidth);
    end else begin
      eff_w = CMP_W'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      eff_h = CMP_W'(1);
    end else if (CMP_W'(frame_height_i) > CMP_W'(MaxHeight)) begin
      eff_h = CMP_W'(MaxHeight);
    end else begin
      eff_h = CMP_W'(frame_height_i);
    end
  end

  assign last_col    = eff_w - CMP_W'(1);
  assign last_row    = eff_h - CMP_W'(1);
  assign row_end     = CMP_W'(col_q) >= last_col;
  assign frame_end_o = row_end && (CMP_W'(row_q) >= last_row);
  assign col_o       = col_q;
  assign row_o       = row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc_i) begin
      if (frame_end_o) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(col_q) <= CMP_W'(MaxWidth - 1))
    else $error("column count beyond maximum width");

endmodule

[rtl/ncps_dist.sv]
module ncps_dist #(
  parameter int unsigned TagW = 23
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  ncps_pkg::color_t              pixel_i,
  input  ncps_pkg::color_t              ref_i,
  input  logic [TagW-1:0]               tag_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [ncps_pkg::DIST_W-1:0]   dist_o,
  output logic [TagW-1:0]               tag_o
);
  import ncps_pkg::*;

  logic              va_q, vb_q, vc_q, vd_q;
  logic              rdy_a, rdy_b, rdy_c, rdy_d;
  color_t            pix_q;
  logic [TagW-1:0]   tag_a_q, tag_b_q, tag_c_q, tag_d_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [PIX_W-1:0]  dy, dr, db;
  logic [SQ_W-1:0]   sy, sr, sb;
  logic [PROD_W-1:0] prod;

  assign rdy_d   = !vd_q || ready_i;
  assign rdy_c   = !vc_q || rdy_d;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  assign dy = (pix_q.luma >= ref_i.luma) ? pix_q.luma - ref_i.luma
                                         : ref_i.luma - pix_q.luma;
  assign dr = (pix_q.red_chroma >= ref_i.red_chroma)
              ? pix_q.red_chroma - ref_i.red_chroma
              : ref_i.red_chroma - pix_q.red_chroma;
  assign db = (pix_q.blue_chroma >= ref_i.blue_chroma)
              ? pix_q.blue_chroma - ref_i.blue_chroma
              : ref_i.blue_chroma - pix_q.blue_chroma;
  assign sy = SQ_W'(dy) * SQ_W'(dy);
  assign sr = SQ_W'(dr) * SQ_W'(dr);
  assign sb = SQ_W'(db) * SQ_W'(db);
  assign sum_d = SUM_W'(sy) + SUM_W'(sr) + SUM_W'(sb);

  assign prod   = PROD_W'(sum_q) * PROD_W'(RECIP6);
  assign quot_d = prod[QUOT_SHIFT +: QUOT_W];

  // Restoring square root, two radicand bits per step.
  always_comb begin
    logic [SUM_W-1:0]    rem;
    logic [SUM_W-1:0]    trial;
    logic [DIST_W-1:0]   root;
    logic [2*DIST_W-1:0] val;
    val  = (2*DIST_W)'(quot_q);
    rem  = '0;
    root = '0;
    for (int i = DIST_W - 1; i >= 0; i--) begin
      rem   = {rem[SUM_W-3:0], val[2*i+1 -: 2]};
      trial = SUM_W'({root, 2'b01});
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[DIST_W-2:0], 1'b1};
      end else begin
        root = {root[DIST_W-2:0], 1'b0};
      end
    end
    dist_d = root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
      if (rdy_d) begin
        vd_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      pix_q   <= pixel_i;
      tag_a_q <= tag_i;
    end
    if (rdy_b && va_q) begin
      sum_q   <= sum_d;
      tag_b_q <= tag_a_q;
    end
    if (rdy_c && vb_q) begin
      quot_q  <= quot_d;
      tag_c_q <= tag_b_q;
    end
    if (rdy_d && vc_q) begin
      dist_q  <= dist_d;
      tag_d_q <= tag_c_q;
    end
  end

  assign valid_o = vd_q;
  assign dist_o  = dist_q;
  assign tag_o   = tag_d_q;

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q |-> dist_q <= DIST_MAX)
    else $error("distance beyond its largest possible value");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd_q && !ready_i) |=> (vd_q && $stable(tag_d_q) && $stable(dist_q)))
    else $error("stalled distance word lost or changed");

endmodule

[rtl/ncps_track.sv]
module ncps_track #(
  parameter int unsigned ColW = 11,
  parameter int unsigned RowW = 11
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [ncps_pkg::DIST_W-1:0]     dist_i,
  input  logic [ColW-1:0]                 col_i,
  input  logic [RowW-1:0]                 row_i,
  input  logic                            frame_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ncps_pkg::COORD_W-1:0]    best_column_o,
  output logic [ncps_pkg::COORD_W-1:0]    best_row_o
);
  import ncps_pkg::*;

  logic [DIST_W-1:0] least_q, least_d;
  logic [ColW-1:0]   lcol_q, lcol_d, pick_col, ocol_q;
  logic [RowW-1:0]   lrow_q, lrow_d, pick_row, orow_q;
  logic              oval_q, oval_d;
  logic              acc, better;

  assign ready_o  = !valid_i || !frame_end_i || !oval_q || out_ready_i;
  assign acc      = valid_i && ready_o;
  assign better   = dist_i < least_q;
  assign pick_col = better ? col_i : lcol_q;
  assign pick_row = better ? row_i : lrow_q;

  always_comb begin
    least_d = least_q;
    lcol_d  = lcol_q;
    lrow_d  = lrow_q;
    oval_d  = oval_q && !out_ready_i;
    if (acc) begin
      if (frame_end_i) begin
        least_d = DIST_INIT;
        lcol_d  = '0;
        lrow_d  = '0;
        oval_d  = 1'b1;
      end else if (better) begin
        least_d = dist_i;
        lcol_d  = col_i;
        lrow_d  = row_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      least_q <= DIST_INIT;
      lcol_q  <= '0;
      lrow_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      least_q <= least_d;
      lcol_q  <= lcol_d;
      lrow_q  <= lrow_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && frame_end_i) begin
      ocol_q <= pick_col;
      orow_q <= pick_row;
    end
  end

  assign out_valid_o   = oval_q;
  assign best_column_o = COORD_W'(ocol_q);
  assign best_row_o    = COORD_W'(orow_q);

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && frame_end_i) |=> (least_q == DIST_INIT && lcol_q == '0 && lrow_q == '0))
    else $error("search not re-armed after frame end");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(oval_q) |-> $past(acc && frame_end_i))
    else $error("result raised without a frame end");

endmodule
